FILE: rtl/hdhi_pkg.sv
// Shared constants, types and arithmetic helpers for the Hermite delay-history block.
package hdhi_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int NUM_DELAYS    = 4;
    localparam int NUM_DENSE     = 4;

    localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
    localparam int NEW_W     = HIST_AW + 1;
    localparam int VAL_DEPTH = HISTORY_DEPTH * NUM_DENSE;
    localparam int VAL_AW    = $clog2(VAL_DEPTH);
    localparam int DLY_AW    = (NUM_DELAYS > 1) ? $clog2(NUM_DELAYS) : 1;

    localparam logic signed [47:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [50:0] WIDE_MAX_X = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [50:0] Q_ONE_X = 51'sd65536;

    typedef enum logic [2:0] {
        K_TIME    = 3'd0,
        K_VALUE   = 3'd1,
        K_DERIV   = 3'd2,
        K_QUERY   = 3'd3,
        K_RESTART = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_NOINT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_TRD, S_TCMP, S_LRD1, S_LRD2, S_LRD3, S_DIV,
        S_CHK, S_HM, S_HW, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        H_THETA, H_BSLOPE, H_ESLOPE, H_SCALE, H_DIFF, H_NEST, H_BEGIN, H_FINAL
    } t_hstep;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         entry_index;
        logic [1:0]         dense_index;
        logic [1:0]         delay_index;
        logic signed [31:0] time_point;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] delayed_value;
        logic [1:0]         channel;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } t_mul_req;

    function automatic logic signed [50:0] ext51(input logic signed [47:0] v);
        return {{3{v[47]}}, v};
    endfunction

    function automatic logic signed [47:0] clamp_wide(input logic signed [50:0] v);
        if (v > WIDE_MAX_X) begin
            return WIDE_MAX;
        end else if (v < -WIDE_MAX_X) begin
            return -WIDE_MAX;
        end else begin
            return v[47:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [VAL_AW-1:0] val_addr(input logic [HIST_AW-1:0] e,
                                                   input logic [1:0] d);
        return VAL_AW'(int'(e) * NUM_DENSE + int'(d));
    endfunction

endpackage

FILE: rtl/hdhi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hdhi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/hdhi_mul.sv
// Shared signed Q32.16 multiplier: 24x24 partial products accumulated in turn, round and saturate.
module hdhi_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hdhi_pkg::t_mul_req      i_req,
    output logic                    o_done,
    output logic signed [47:0]      o_res
);
    logic [47:0] r_ma, r_mb;
    logic        r_neg, r_busy, r_fin;
    logic [95:0] r_acc;
    logic [1:0]  r_cnt;
    logic [23:0] pa, pb;
    logic [47:0] prod;
    logic [6:0]  shamt;
    logic [95:0] rnd;
    logic [79:0] q;
    logic [47:0] magr;

    assign pa    = r_cnt[0] ? r_ma[47:24] : r_ma[23:0];
    assign pb    = r_cnt[1] ? r_mb[47:24] : r_mb[23:0];
    assign prod  = pa * pb;
    assign shamt = (r_cnt[0] ? 7'd24 : 7'd0) + (r_cnt[1] ? 7'd24 : 7'd0);
    assign rnd   = r_acc + 96'd32768;
    assign q     = rnd[95:16];
    assign magr  = (|q[79:47]) ? 48'(hdhi_pkg::WIDE_MAX) : {1'b0, q[46:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_fin;
            r_fin  <= r_busy && (r_cnt == 2'd3);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
        if (i_req.start) begin
            r_ma  <= i_req.a[47] ? 48'(-i_req.a) : 48'(i_req.a);
            r_mb  <= i_req.b[47] ? 48'(-i_req.b) : 48'(i_req.b);
            r_neg <= i_req.a[47] ^ i_req.b[47];
            r_acc <= '0;
            r_cnt <= 2'd0;
        end else if (r_busy) begin
            r_acc <= r_acc + (96'(prod) << shamt);
            r_cnt <= r_cnt + 2'd1;
        end
        if (r_fin) begin
            o_res <= r_neg ? -$signed(magr) : $signed(magr);
        end
    end
endmodule

FILE: rtl/hdhi_div.sv
// Restoring divider, one quotient bit per cycle, for the interval reciprocal.
module hdhi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_num;
    logic [30:0] r_den;
    logic [31:0] r_rem;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_num[32]};
    assign ge    = trial >= {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 6'd32);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == 6'd32) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[31:0], 1'b0};
            r_rem <= ge ? 32'(trial - {2'b0, r_den}) : trial[31:0];
            o_quo <= {o_quo[31:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end
endmodule

FILE: rtl/hermite_delay_history_interp_top.sv
// Top level: history stores, per-channel interval cache and query sequencer.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------
//  in       | sink      | i_in_valid/o_in_stall| i_in_data  (t_in_item)
//  out      | source    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | i_cfg_data (dense_select_map)
//
// Writes and restarts are taken while idle, without leaving the idle state. A
// query scans the history one entry at a time through a read state and a
// compare state; loading an interval adds three read states, then the 33-step
// reciprocal divider; interpolation is 8 passes of the shared multiplier, and
// the output state posts the answer. Error answers go to the output state
// without interpolating. The input stalls whenever a query is in flight; a
// finished answer waits in the output register while the next transaction is
// accepted. Reset is synchronous and clears cursors, loaded flags and newest
// count; the history RAMs are not cleared and read as garbage until written.
module hermite_delay_history_interp_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hdhi_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hdhi_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    localparam int HAW = hdhi_pkg::HIST_AW;
    localparam int NW  = hdhi_pkg::NEW_W;
    localparam int VAW = hdhi_pkg::VAL_AW;
    localparam int DAW = hdhi_pkg::DLY_AW;
    localparam int ND  = hdhi_pkg::NUM_DELAYS;

    hdhi_pkg::t_state r_state, n_state;
    hdhi_pkg::t_hstep r_step;
    hdhi_pkg::t_status r_status;

    logic [7:0]  r_map;
    logic [NW-1:0] r_newest;
    logic [NW-1:0] r_nxt [ND];
    logic [ND-1:0] r_loaded;
    logic signed [31:0] r_cstart [ND];
    logic signed [31:0] r_clen   [ND];
    logic [31:0]        r_cinv   [ND];
    logic signed [31:0] r_cbv [ND];
    logic signed [31:0] r_cev [ND];
    logic signed [31:0] r_cbs [ND];
    logic signed [31:0] r_ces [ND];

    // Query working registers.
    logic signed [31:0] r_t, r_tk, r_tk1, r_xn, r_xb, r_dn, r_db, r_len;
    logic [1:0]  r_c, r_dv;
    logic [NW-1:0] r_k;
    logic        r_first;
    logic signed [47:0] r_th, r_thm1, r_p, r_sc, r_om;
    logic signed [31:0] r_res;
    logic        r_ovalid;
    hdhi_pkg::t_out_item r_out;

    // Datapath helpers.
    logic        in_acc, is_query, bad_ch, ent_ok, dense_ok;
    logic        time_we, val_we, der_we;
    logic [HAW-1:0] k_lo, km1_lo, time_raddr, w_entry;
    logic [VAW-1:0] val_raddr, val_waddr;
    logic [31:0] time_rdata, val_rdata, der_rdata;
    logic        k_lt, t_lt, can_load;
    logic [1:0]  dv_raw, dv_sel;
    logic [DAW-1:0] ci, qi;
    logic signed [32:0] len_diff;
    logic signed [31:0] len_sat;
    logic [32:0] quo;
    logic        div_done, mul_done;
    logic signed [47:0] mul_res;
    hdhi_pkg::t_mul_req mreq;
    logic signed [32:0] tdiff, xdiff;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_query = i_in_data.kind == hdhi_pkg::K_QUERY;
    assign bad_ch   = int'(i_in_data.delay_index) >= ND;
    assign ent_ok   = int'(i_in_data.entry_index) < hdhi_pkg::HISTORY_DEPTH;
    assign dense_ok = int'(i_in_data.dense_index) < hdhi_pkg::NUM_DENSE;
    assign w_entry  = HAW'(i_in_data.entry_index);
    assign time_we  = in_acc && i_in_data.kind == hdhi_pkg::K_TIME && ent_ok;
    assign val_we   = in_acc && i_in_data.kind == hdhi_pkg::K_VALUE && ent_ok && dense_ok;
    assign der_we   = in_acc && i_in_data.kind == hdhi_pkg::K_DERIV && ent_ok && dense_ok;
    assign val_waddr = hdhi_pkg::val_addr(w_entry, i_in_data.dense_index);

    assign o_in_stall  = r_state != hdhi_pkg::S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign can_load    = !r_ovalid || !i_out_stall;

    // Map a delay channel to its dense variable, clamped to the last one.
    assign dv_raw = r_map[{i_in_data.delay_index, 1'b0} +: 2];
    assign dv_sel = (int'(dv_raw) >= hdhi_pkg::NUM_DENSE) ?
                    2'(hdhi_pkg::NUM_DENSE - 1) : dv_raw;
    assign qi = DAW'(i_in_data.delay_index);
    assign ci = DAW'(r_c);

    assign k_lo       = r_k[HAW-1:0];
    assign km1_lo     = HAW'(r_k - NW'(1));
    assign time_raddr = (r_state == hdhi_pkg::S_LRD1) ? km1_lo : k_lo;
    assign val_raddr  = (r_state == hdhi_pkg::S_LRD2) ?
                        hdhi_pkg::val_addr(km1_lo, r_dv) : hdhi_pkg::val_addr(k_lo, r_dv);
    assign k_lt = r_k < r_newest;
    assign t_lt = r_t < $signed(time_rdata);

    // Interval length, kept within [1, 2^31-1].
    assign len_diff = {r_tk[31], r_tk} - {r_tk1[31], r_tk1};
    assign len_sat  = (len_diff > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                      (len_diff < 33'sd1) ? 32'sd1 : len_diff[31:0];

    hdhi_ram #(.WIDTH(32), .DEPTH(hdhi_pkg::HISTORY_DEPTH)) u_time (
        .i_clk(i_clk), .i_we(time_we), .i_waddr(w_entry),
        .i_wdata(i_in_data.time_point), .i_raddr(time_raddr), .o_rdata(time_rdata));
    hdhi_ram #(.WIDTH(32), .DEPTH(hdhi_pkg::VAL_DEPTH)) u_value (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr),
        .i_wdata(i_in_data.sample), .i_raddr(val_raddr), .o_rdata(val_rdata));
    hdhi_ram #(.WIDTH(32), .DEPTH(hdhi_pkg::VAL_DEPTH)) u_deriv (
        .i_clk(i_clk), .i_we(der_we), .i_waddr(val_waddr),
        .i_wdata(i_in_data.sample), .i_raddr(val_raddr), .o_rdata(der_rdata));

    hdhi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == hdhi_pkg::S_LRD3),
        .i_num(33'h1_0000_0000 + 33'(len_sat[31:1])),
        .i_den(len_sat[30:0]),
        .o_done(div_done), .o_quo(quo));

    hdhi_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq),
        .o_done(mul_done), .o_res(mul_res));

    // Operand select for each pass of the shared multiplier.
    assign tdiff = {r_t[31], r_t} - {r_cstart[ci][31], r_cstart[ci]};
    assign xdiff = {r_cev[ci][31], r_cev[ci]} - {r_cbv[ci][31], r_cbv[ci]};

    always_comb begin
        mreq.start = r_state == hdhi_pkg::S_HM;
        case (r_step)
            hdhi_pkg::H_THETA: begin
                mreq.a = {{15{tdiff[32]}}, tdiff};
                mreq.b = {16'b0, r_cinv[ci]};
            end
            hdhi_pkg::H_BSLOPE: begin
                mreq.a = r_thm1;
                mreq.b = {{16{r_cbs[ci][31]}}, r_cbs[ci]};
            end
            hdhi_pkg::H_ESLOPE: begin
                mreq.a = r_th;
                mreq.b = {{16{r_ces[ci][31]}}, r_ces[ci]};
            end
            hdhi_pkg::H_SCALE: begin
                mreq.a = {{16{r_clen[ci][31]}}, r_clen[ci]};
                mreq.b = r_p;
            end
            hdhi_pkg::H_DIFF: begin
                mreq.a = r_om;
                mreq.b = {{15{xdiff[32]}}, xdiff};
            end
            hdhi_pkg::H_NEST: begin
                mreq.a = r_thm1;
                mreq.b = r_p;
            end
            hdhi_pkg::H_BEGIN: begin
                mreq.a = -r_thm1;
                mreq.b = {{16{r_cbv[ci][31]}}, r_cbv[ci]};
            end
            default: begin
                mreq.a = r_th;
                mreq.b = r_p;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hdhi_pkg::S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = bad_ch ? hdhi_pkg::S_OUT : hdhi_pkg::S_TRD;
                end
            end
            hdhi_pkg::S_TRD:  n_state = hdhi_pkg::S_TCMP;
            hdhi_pkg::S_TCMP: begin
                if (r_first && k_lt && t_lt) begin
                    n_state = hdhi_pkg::S_CHK;
                end else if (k_lt && !t_lt) begin
                    n_state = hdhi_pkg::S_TRD;
                end else if (!k_lt || r_k == '0) begin
                    n_state = hdhi_pkg::S_OUT;
                end else begin
                    n_state = hdhi_pkg::S_LRD1;
                end
            end
            hdhi_pkg::S_LRD1: n_state = hdhi_pkg::S_LRD2;
            hdhi_pkg::S_LRD2: n_state = hdhi_pkg::S_LRD3;
            hdhi_pkg::S_LRD3: n_state = hdhi_pkg::S_DIV;
            hdhi_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = hdhi_pkg::S_HM;
                end
            end
            hdhi_pkg::S_CHK: begin
                n_state = r_loaded[ci] ? hdhi_pkg::S_HM : hdhi_pkg::S_OUT;
            end
            hdhi_pkg::S_HM: n_state = hdhi_pkg::S_HW;
            hdhi_pkg::S_HW: begin
                if (mul_done) begin
                    n_state = (r_step == hdhi_pkg::H_FINAL) ? hdhi_pkg::S_OUT
                                                            : hdhi_pkg::S_HM;
                end
            end
            hdhi_pkg::S_OUT: begin
                if (can_load) begin
                    n_state = hdhi_pkg::S_IDLE;
                end
            end
            default: n_state = hdhi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hdhi_pkg::S_IDLE;
            r_map    <= '0;
            r_newest <= '0;
            r_loaded <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < ND; i++) begin
                r_nxt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_map <= i_cfg_data;
            end
            if (time_we) begin
                r_newest <= NW'(i_in_data.entry_index) + NW'(1);
            end
            // Restart: drop every cursor and cached interval.
            if (in_acc && i_in_data.kind == hdhi_pkg::K_RESTART) begin
                r_loaded <= '0;
                for (int i = 0; i < ND; i++) begin
                    r_nxt[i] <= '0;
                end
            end
            // Commit the new interval once its reciprocal is ready.
            if (r_state == hdhi_pkg::S_DIV && div_done) begin
                r_loaded[ci] <= 1'b1;
                r_nxt[ci]    <= r_k;
            end
            if (r_state == hdhi_pkg::S_OUT && can_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Query datapath, no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            hdhi_pkg::S_IDLE: begin
                r_t      <= i_in_data.time_point;
                r_c      <= i_in_data.delay_index;
                r_dv     <= dv_sel;
                r_k      <= r_nxt[qi];
                r_first  <= 1'b1;
                r_step   <= hdhi_pkg::H_THETA;
                r_status <= bad_ch ? hdhi_pkg::ST_NOINT : hdhi_pkg::ST_OK;
            end
            hdhi_pkg::S_TCMP: begin
                r_tk <= time_rdata;
                if (!(r_first && k_lt && t_lt)) begin
                    if (k_lt && !t_lt) begin
                        r_k     <= r_k + NW'(1);
                        r_first <= 1'b0;
                    end else if (!k_lt || r_k == '0) begin
                        r_status <= hdhi_pkg::ST_BEYOND;
                    end
                end
            end
            hdhi_pkg::S_LRD2: begin
                r_tk1 <= time_rdata;
                r_xn  <= val_rdata;
                r_dn  <= der_rdata;
            end
            hdhi_pkg::S_LRD3: begin
                r_xb  <= val_rdata;
                r_db  <= der_rdata;
                r_len <= len_sat;
            end
            hdhi_pkg::S_DIV: begin
                if (div_done) begin
                    r_cstart[ci] <= r_tk1;
                    r_clen[ci]   <= r_len;
                    r_cinv[ci]   <= (|quo[32]) ? 32'hFFFF_FFFF : quo[31:0];
                    r_cbv[ci]    <= r_xb;
                    r_cev[ci]    <= r_xn;
                    r_cbs[ci]    <= r_db;
                    r_ces[ci]    <= r_dn;
                end
            end
            hdhi_pkg::S_CHK: begin
                if (!r_loaded[ci]) begin
                    r_status <= hdhi_pkg::ST_NOINT;
                end
            end
            hdhi_pkg::S_HW: begin
                if (mul_done) begin
                    r_step <= hdhi_pkg::t_hstep'(r_step + 3'd1);
                    case (r_step)
                        hdhi_pkg::H_THETA: begin
                            r_th   <= mul_res;
                            r_thm1 <= hdhi_pkg::clamp_wide(hdhi_pkg::ext51(mul_res)
                                                           - hdhi_pkg::Q_ONE_X);
                        end
                        hdhi_pkg::H_BSLOPE: r_p <= mul_res;
                        hdhi_pkg::H_ESLOPE: begin
                            r_p <= hdhi_pkg::clamp_wide(hdhi_pkg::ext51(r_p)
                                                        + hdhi_pkg::ext51(mul_res));
                        end
                        hdhi_pkg::H_SCALE: begin
                            r_sc <= mul_res;
                            r_om <= hdhi_pkg::clamp_wide(hdhi_pkg::Q_ONE_X
                                        - (hdhi_pkg::ext51(r_th) <<< 1));
                        end
                        hdhi_pkg::H_DIFF: begin
                            r_p <= hdhi_pkg::clamp_wide(hdhi_pkg::ext51(mul_res)
                                                        + hdhi_pkg::ext51(r_sc));
                        end
                        hdhi_pkg::H_NEST: begin
                            r_p <= hdhi_pkg::clamp_wide(
                                       hdhi_pkg::ext51({{16{r_cev[ci][31]}}, r_cev[ci]})
                                       + hdhi_pkg::ext51(mul_res));
                        end
                        hdhi_pkg::H_BEGIN: r_sc <= mul_res;
                        default: begin
                            r_res <= hdhi_pkg::sat32(hdhi_pkg::ext51(r_sc)
                                                     + hdhi_pkg::ext51(mul_res));
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        if (r_state == hdhi_pkg::S_OUT && can_load) begin
            r_out.delayed_value <= (r_status == hdhi_pkg::ST_OK) ? r_res : 32'sd0;
            r_out.channel       <= r_c;
            r_out.status        <= r_status;
        end
    end

    // The newest count never passes the history depth.
    a_newest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_newest) <= hdhi_pkg::HISTORY_DEPTH)
        else $error("newest entry count beyond history depth");

    // Interpolation only ever starts on a loaded interval.
    a_hm_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdhi_pkg::S_HM) |-> r_loaded[ci])
        else $error("interpolation started without a loaded interval");

    // Multiplier results arrive only while the sequencer waits for them.
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == hdhi_pkg::S_HW))
        else $error("multiplier result outside wait state");

    // Divider results arrive only while the sequencer waits for them.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == hdhi_pkg::S_DIV))
        else $error("divider result outside wait state");
endmodule
